@@ rtl/core/rbm_pkg.sv @@
// Package for the region block mosaic: default sizes, coordinate type,
// command and register codes, and reset values of the frame size and block size registers.
// Depends on nothing; used by region_block_mosaic.
package rbm_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int MAX_BLOCK_DEF  = 64;

   localparam int PIX_W   = 8;
   localparam int CRD_W   = 12;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;
   localparam int FRM_W   = 9;
   localparam int BOX_W   = 10;
   localparam int BSZ_W   = 7;

   typedef logic signed [CRD_W-1:0] crd_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_APPLY = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_BOX_LEFT     = 3'd2,
      REG_BOX_TOP      = 3'd3,
      REG_BOX_WIDTH    = 3'd4,
      REG_BOX_HEIGHT   = 3'd5,
      REG_BLOCK_SIZE   = 3'd6
   } reg_index_type;

   localparam logic [FRM_W-1:0] FRAME_WIDTH_RST  = 9'd256;
   localparam logic [FRM_W-1:0] FRAME_HEIGHT_RST = 9'd256;
   localparam logic [BSZ_W-1:0] BLOCK_SIZE_RST   = 7'd8;

endpackage

@@ rtl/core/region_block_mosaic.sv @@
// Region block mosaic: luma frame store with pixel write/read and box pixelation.
// Depends on rbm_pkg and rbm_ram.
//
//   Port group   Direction  Handshake               Carries
//   req_*        in         req_valid / req_stall   opcode, pixel_x, pixel_y, pixel_value
//   rsp_*        out        rsp_valid / rsp_stall   read_value, apply_done, apply_skipped
//   APB          in/out     psel, penable, pready   register writes and reads
//
// Writes and reads are accepted one per cycle when the input is not stalled. A read result is
// taken from the registered read port of the pixel store and loaded into the output register.
// An apply stalls the input while it walks each block of n pixels (n reads, n writes and
// a divider that yields one quotient bit per cycle) and while it loads its result.
// Reset restores the register defaults; the pixel store is not cleared.
// Input is also stalled while a read result waits behind a stalled output register.
module region_block_mosaic #(
   parameter int MAX_WIDTH  = rbm_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = rbm_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_BLOCK  = rbm_pkg::MAX_BLOCK_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_opcode,
   input  logic [rbm_pkg::PIX_W-1:0]   req_pixel_x,
   input  logic [rbm_pkg::PIX_W-1:0]   req_pixel_y,
   input  logic [rbm_pkg::PIX_W-1:0]   req_pixel_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rbm_pkg::PIX_W-1:0]   rsp_read_value,
   output logic                        rsp_apply_done,
   output logic                        rsp_apply_skipped,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rbm_pkg::CSR_AW-1:0]  paddr,
   input  logic [rbm_pkg::CSR_DW-1:0]  pwdata,
   output logic [rbm_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);

   import rbm_pkg::*;

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int AW    = XW + YW;
   localparam int CNT_W = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
   localparam int SUM_W = CNT_W + PIX_W;
   localparam int DW    = SUM_W + 1;
   localparam int STW   = $clog2(PIX_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BLOCK,
      ST_READ,
      ST_DRAIN,
      ST_DIV,
      ST_WRITE,
      ST_NEXT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [FRM_W-1:0]        frame_width_ff, frame_width_in;
   logic [FRM_W-1:0]        frame_height_ff, frame_height_in;
   logic signed [BOX_W-1:0] box_left_ff, box_left_in;
   logic signed [BOX_W-1:0] box_top_ff, box_top_in;
   logic [BOX_W-1:0]        box_width_ff, box_width_in;
   logic [BOX_W-1:0]        box_height_ff, box_height_in;
   logic [BSZ_W-1:0]        block_size_ff, block_size_in;

   crd_type x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in, bs_ff, bs_in;
   crd_type bx_ff, bx_in, by_ff, by_in, bx1_ff, bx1_in, by1_ff, by1_in;
   crd_type cx_ff, cx_in, cy_ff, cy_in;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PIX_W-1:0] avg_ff, avg_in;
   logic [STW-1:0]   step_ff, step_in;
   logic             acc_vld_ff, acc_vld_in;
   logic             skip_ff, skip_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             rd_zero_ff, rd_zero_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_done_ff, rsp_done_in;
   logic             rsp_skip_ff, rsp_skip_in;

   crd_type fw_c, fh_c, bs_c, left_c, top_c, xe_c, ye_c, x0_c, y0_c, x1_c, y1_c;
   crd_type bx_end_c, by_end_c;
   logic    skip_c;
   logic    req_accept, out_free, req_inside, cfg_write;
   logic [2:0]    csr_index;
   logic [DW-1:0] div_sub, div_trial;

   logic             ram_wr_en, ram_rd_en;
   logic [AW-1:0]    ram_wr_addr, ram_rd_addr, req_addr, cur_addr;
   logic [PIX_W-1:0] ram_wr_data, ram_rd_data;

   rbm_ram #(
      .WIDTH (PIX_W),
      .DEPTH (2 ** AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || (rd_pend_ff && !out_free);
   assign req_accept = req_valid && !req_stall;
   assign req_inside = (int'(req_pixel_x) < MAX_WIDTH) && (int'(req_pixel_y) < MAX_HEIGHT);
   assign req_addr   = {YW'(req_pixel_y), XW'(req_pixel_x)};
   assign cur_addr   = {YW'(cy_ff), XW'(cx_ff)};
   assign cfg_write  = psel && penable && pwrite && pready;
   assign csr_index  = paddr[4:2];

   assign fw_c   = (int'(frame_width_ff) > MAX_WIDTH) ? crd_type'(MAX_WIDTH)
                                                       : crd_type'(frame_width_ff);
   assign fh_c   = (int'(frame_height_ff) > MAX_HEIGHT) ? crd_type'(MAX_HEIGHT)
                                                         : crd_type'(frame_height_ff);
   assign bs_c   = (int'(block_size_ff) > MAX_BLOCK) ? crd_type'(MAX_BLOCK)
                                                      : crd_type'(block_size_ff);
   assign left_c = crd_type'(box_left_ff);
   assign top_c  = crd_type'(box_top_ff);
   assign xe_c   = left_c + crd_type'(box_width_ff);
   assign ye_c   = top_c + crd_type'(box_height_ff);
   assign x0_c   = (left_c < 0) ? crd_type'(0) : left_c;
   assign y0_c   = (top_c < 0) ? crd_type'(0) : top_c;
   assign x1_c   = (xe_c < fw_c) ? xe_c : fw_c;
   assign y1_c   = (ye_c < fh_c) ? ye_c : fh_c;
   assign skip_c = (bs_c <= crd_type'(1)) || (x1_c <= x0_c) || (y1_c <= y0_c);

   assign bx_end_c = ((bx_ff + bs_ff) < x1_ff) ? (bx_ff + bs_ff) : x1_ff;
   assign by_end_c = ((by_ff + bs_ff) < y1_ff) ? (by_ff + bs_ff) : y1_ff;

   assign div_sub   = DW'(count_ff) << step_ff;
   assign div_trial = DW'(sum_ff) - div_sub;

   always_comb begin
      case (reg_index_type'(csr_index))
         REG_FRAME_WIDTH:  prdata = CSR_DW'(frame_width_ff);
         REG_FRAME_HEIGHT: prdata = CSR_DW'(frame_height_ff);
         REG_BOX_LEFT:     prdata = {{(CSR_DW-BOX_W){1'b0}}, box_left_ff};
         REG_BOX_TOP:      prdata = {{(CSR_DW-BOX_W){1'b0}}, box_top_ff};
         REG_BOX_WIDTH:    prdata = CSR_DW'(box_width_ff);
         REG_BOX_HEIGHT:   prdata = CSR_DW'(box_height_ff);
         REG_BLOCK_SIZE:   prdata = CSR_DW'(block_size_ff);
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      box_left_in     = box_left_ff;
      box_top_in      = box_top_ff;
      box_width_in    = box_width_ff;
      box_height_in   = box_height_ff;
      block_size_in   = block_size_ff;
      x0_in           = x0_ff;
      x1_in           = x1_ff;
      y1_in           = y1_ff;
      bs_in           = bs_ff;
      bx_in           = bx_ff;
      by_in           = by_ff;
      bx1_in          = bx1_ff;
      by1_in          = by1_ff;
      cx_in           = cx_ff;
      cy_in           = cy_ff;
      sum_in          = sum_ff;
      count_in        = count_ff;
      avg_in          = avg_ff;
      step_in         = step_ff;
      acc_vld_in      = 1'b0;
      skip_in         = skip_ff;
      rd_pend_in      = rd_pend_ff;
      rd_zero_in      = rd_zero_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_done_in     = rsp_done_ff;
      rsp_skip_in     = rsp_skip_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = req_addr;
      ram_wr_data     = req_pixel_value;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = req_addr;

      if (cfg_write) begin
         case (reg_index_type'(csr_index))
            REG_FRAME_WIDTH:  frame_width_in  = pwdata[FRM_W-1:0];
            REG_FRAME_HEIGHT: frame_height_in = pwdata[FRM_W-1:0];
            REG_BOX_LEFT:     box_left_in     = pwdata[BOX_W-1:0];
            REG_BOX_TOP:      box_top_in      = pwdata[BOX_W-1:0];
            REG_BOX_WIDTH:    box_width_in    = pwdata[BOX_W-1:0];
            REG_BOX_HEIGHT:   box_height_in   = pwdata[BOX_W-1:0];
            REG_BLOCK_SIZE:   block_size_in   = pwdata[BSZ_W-1:0];
            default: ;
         endcase
      end

      if (acc_vld_ff) begin
         sum_in   = sum_ff + SUM_W'(ram_rd_data);
         count_in = count_ff + CNT_W'(1);
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rd_pend_ff && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = rd_zero_ff ? '0 : ram_rd_data;
         rsp_done_in  = 1'b0;
         rsp_skip_in  = 1'b0;
         rd_pend_in   = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_opcode)
                  OP_WRITE: begin
                     ram_wr_en = req_inside;
                  end
                  OP_APPLY: begin
                     x0_in    = x0_c;
                     x1_in    = x1_c;
                     y1_in    = y1_c;
                     bs_in    = bs_c;
                     bx_in    = x0_c;
                     by_in    = y0_c;
                     skip_in  = skip_c;
                     state_in = skip_c ? ST_DONE : ST_BLOCK;
                  end
                  OP_READ: begin
                     ram_rd_en  = req_inside;
                     rd_pend_in = 1'b1;
                     rd_zero_in = !req_inside;
                  end
                  default: ;
               endcase
            end
         end
         ST_BLOCK: begin
            bx1_in   = bx_end_c;
            by1_in   = by_end_c;
            cx_in    = bx_ff;
            cy_in    = by_ff;
            sum_in   = '0;
            count_in = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = cur_addr;
            acc_vld_in  = 1'b1;
            if (cx_ff + crd_type'(1) == bx1_ff) begin
               cx_in = bx_ff;
               if (cy_ff + crd_type'(1) == by1_ff) begin
                  cy_in    = by_ff;
                  state_in = ST_DRAIN;
               end else begin
                  cy_in = cy_ff + crd_type'(1);
               end
            end else begin
               cx_in = cx_ff + crd_type'(1);
            end
         end
         ST_DRAIN: begin
            step_in  = STW'(PIX_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!div_trial[DW-1]) begin
               sum_in = div_trial[SUM_W-1:0];
            end
            avg_in  = {avg_ff[PIX_W-2:0], !div_trial[DW-1]};
            step_in = step_ff - STW'(1);
            if (step_ff == '0) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cur_addr;
            ram_wr_data = avg_ff;
            if (cx_ff + crd_type'(1) == bx1_ff) begin
               cx_in = bx_ff;
               if (cy_ff + crd_type'(1) == by1_ff) begin
                  state_in = ST_NEXT;
               end else begin
                  cy_in = cy_ff + crd_type'(1);
               end
            end else begin
               cx_in = cx_ff + crd_type'(1);
            end
         end
         ST_NEXT: begin
            state_in = ST_BLOCK;
            if (bx_ff + bs_ff >= x1_ff) begin
               bx_in = x0_ff;
               by_in = by_ff + bs_ff;
               if (by_ff + bs_ff >= y1_ff) begin
                  state_in = ST_DONE;
               end
            end else begin
               bx_in = bx_ff + bs_ff;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_done_in  = 1'b1;
               rsp_skip_in  = skip_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         box_left_ff     <= '0;
         box_top_ff      <= '0;
         box_width_ff    <= '0;
         box_height_ff   <= '0;
         block_size_ff   <= BLOCK_SIZE_RST;
         acc_vld_ff      <= 1'b0;
         rd_pend_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         box_left_ff     <= box_left_in;
         box_top_ff      <= box_top_in;
         box_width_ff    <= box_width_in;
         box_height_ff   <= box_height_in;
         block_size_ff   <= block_size_in;
         acc_vld_ff      <= acc_vld_in;
         rd_pend_ff      <= rd_pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      x0_ff        <= x0_in;
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      bs_ff        <= bs_in;
      bx_ff        <= bx_in;
      by_ff        <= by_in;
      bx1_ff       <= bx1_in;
      by1_ff       <= by1_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      sum_ff       <= sum_in;
      count_ff     <= count_in;
      avg_ff       <= avg_in;
      step_ff      <= step_in;
      skip_ff      <= skip_in;
      rd_zero_ff   <= rd_zero_in;
      rsp_value_ff <= rsp_value_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_skip_ff  <= rsp_skip_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_value    = rsp_value_ff;
   assign rsp_apply_done    = rsp_done_ff;
   assign rsp_apply_skipped = rsp_skip_ff;
   assign pready            = 1'b1;

`ifndef SYNTHESIS
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("input taken while an apply is in progress");

   a_read_only_idle: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == ST_IDLE))
      else $error("pending read overlaps the apply walk");

   a_acc_in_walk: assert property (@(posedge clock) disable iff (reset)
      acc_vld_ff |-> (state_ff == ST_READ || state_ff == ST_DRAIN))
      else $error("pixel accumulated outside the block read");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (count_ff != '0))
      else $error("block mean divided by zero pixel count");
`endif

endmodule

@@ rtl/core/rbm_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Read data changes only on a read enable. Depends on nothing.
module rbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
